>>> rtl/cisu_pkg.sv
// ----------------------------------------------------------------------------
// cisu_pkg
// Types, character codes, unit weights and error codes shared by the
// interval string converter.
// ----------------------------------------------------------------------------
package cisu_pkg;

  typedef logic [7:0]         char_t;
  typedef logic [2:0]         mode_t;
  typedef logic [1:0]         err_t;
  typedef logic [62:0]        group_t;
  typedef logic [2:0]         gcnt_t;
  typedef logic [63:0]        prod_t;
  typedef logic signed [63:0] total_t;

  // Per-string summary handed from the parser to the arithmetic pipeline.
  typedef struct packed {
    logic  zero;   // empty string, result is forced to zero
    logic  neg;    // first non-space character was a minus sign
    logic  ovf;    // some digit run went beyond the Int64 maximum
    gcnt_t cnt;    // closed digit runs, saturating
  } str_info_t;

  localparam int unsigned GROUP_W = 63;
  localparam int unsigned QDEPTH  = 2;

  localparam group_t GROUP_MAX = {GROUP_W{1'b1}};

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  localparam err_t ERR_OK     = 2'd0;
  localparam err_t ERR_GROUPS = 2'd1;
  localparam err_t ERR_RANGE  = 2'd2;

  localparam mode_t MODE_HOUR_SEC   = 3'd0;
  localparam mode_t MODE_HOUR_MIN   = 3'd1;
  localparam mode_t MODE_MIN_SEC    = 3'd2;
  localparam mode_t MODE_DAY_SEC    = 3'd3;
  localparam mode_t MODE_DAY_MIN    = 3'd4;
  localparam mode_t MODE_DAY_HOUR   = 3'd5;
  localparam mode_t MODE_YEAR_MONTH = 3'd6;

  localparam prod_t W_60    = 64'd60;
  localparam prod_t W_24    = 64'd24;
  localparam prod_t W_12    = 64'd12;
  localparam prod_t W_3600  = 64'd3600;
  localparam prod_t W_1440  = 64'd1440;
  localparam prod_t W_86400 = 64'd86400;

  // Number of digit groups a mode consumes. The spare code acts as hour-sec.
  function automatic gcnt_t mode_groups(input mode_t mode);
    gcnt_t n;
    case (mode)
      MODE_HOUR_SEC:   n = 3'd3;
      MODE_HOUR_MIN:   n = 3'd2;
      MODE_MIN_SEC:    n = 3'd2;
      MODE_DAY_SEC:    n = 3'd4;
      MODE_DAY_MIN:    n = 3'd3;
      MODE_DAY_HOUR:   n = 3'd2;
      MODE_YEAR_MONTH: n = 3'd2;
      default:         n = 3'd3;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/cisu_if.sv
// ----------------------------------------------------------------------------
// cisu_if
// Valid/ready channels for string bytes in and interval results out.
// ----------------------------------------------------------------------------
interface cisu_in_if;
  logic            valid;
  logic            ready;
  cisu_pkg::char_t char_code;
  logic            last_char;
  logic            empty_row;

  modport source (output valid, char_code, last_char, empty_row, input ready);
  modport sink   (input valid, char_code, last_char, empty_row, output ready);
endinterface

interface cisu_out_if;
  logic             valid;
  logic             ready;
  cisu_pkg::total_t total_value;
  cisu_pkg::err_t   error_code;

  modport source (output valid, total_value, error_code, input ready);
  modport sink   (input valid, total_value, error_code, output ready);
endinterface

>>> rtl/cisu_front.sv
// ----------------------------------------------------------------------------
// cisu_front
// Byte parser: tracks sign, accumulates digit runs and keeps the most recent
// groups. Pushes one string summary per last byte or empty row.
// ----------------------------------------------------------------------------
module cisu_front #(
  parameter int unsigned MAX_GROUPS = 4
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         byte_valid,
  input  cisu_pkg::char_t                              char_code,
  input  logic                                         last_char,
  input  logic                                         empty_row,
  input  logic                                         q_full,
  output logic                                         byte_ready,
  output logic                                         push,
  output cisu_pkg::str_info_t                          push_info,
  output logic [MAX_GROUPS-1:0][cisu_pkg::GROUP_W-1:0] push_groups
);
  import cisu_pkg::*;

  localparam gcnt_t CntSat = gcnt_t'(MAX_GROUPS + 1);

  logic                               ns_r, neg_r, ind_r, ovf_r;
  group_t                             cur_r;
  logic [MAX_GROUPS-1:0][GROUP_W-1:0] grp_r;
  gcnt_t                              cnt_r;

  logic                               ns_nxt, neg_nxt, ind_nxt, ovf_nxt;
  group_t                             cur_nxt;
  logic [MAX_GROUPS-1:0][GROUP_W-1:0] grp_nxt;
  gcnt_t                              cnt_nxt;

  logic        accept, is_digit, dig_ovf, do_close, finish;
  logic [3:0]  dig;
  logic [66:0] acc10;
  group_t      cur_dig, close_val;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign finish     = last_char || empty_row;

  always_comb begin
    is_digit = (char_code inside {[CH_ZERO:CH_NINE]});
    dig      = 4'(char_code - CH_ZERO);
    // value*10 + digit; anything above bit 62 means the run left Int64 range
    acc10    = 67'({cur_r, 3'b000}) + 67'({cur_r, 1'b0}) + 67'(dig);
    dig_ovf  = |acc10[66:63];
    cur_dig  = dig_ovf ? GROUP_MAX : acc10[62:0];

    ns_nxt  = ns_r;
    neg_nxt = neg_r;
    if (!ns_r && char_code != CH_SPACE) begin
      ns_nxt  = 1'b1;
      neg_nxt = (char_code == CH_MINUS);
    end

    // At most one run closes per byte: a non-digit ends an open run, and a
    // digit on the last byte ends the run it belongs to.
    do_close  = is_digit ? last_char : ind_r;
    close_val = is_digit ? cur_dig : cur_r;

    if (is_digit) begin
      cur_nxt = cur_dig;
      ind_nxt = 1'b1;
      ovf_nxt = ovf_r | dig_ovf;
    end else begin
      cur_nxt = '0;
      ind_nxt = 1'b0;
      ovf_nxt = ovf_r;
    end

    grp_nxt = grp_r;
    cnt_nxt = cnt_r;
    if (do_close) begin
      grp_nxt[0] = close_val;
      for (int i = 1; i < MAX_GROUPS; i++) begin
        grp_nxt[i] = grp_r[i-1];
      end
      if (cnt_r < CntSat) begin
        cnt_nxt = cnt_r + 3'd1;
      end
      cur_nxt = '0;
      ind_nxt = 1'b0;
    end
  end

  assign push             = accept && finish;
  assign push_info.zero   = empty_row;
  assign push_info.neg    = neg_nxt;
  assign push_info.ovf    = ovf_nxt;
  assign push_info.cnt    = cnt_nxt;
  assign push_groups      = grp_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r  <= 1'b0;
      neg_r <= 1'b0;
      ind_r <= 1'b0;
      ovf_r <= 1'b0;
      cur_r <= '0;
      grp_r <= '0;
      cnt_r <= '0;
    end else if (accept) begin
      if (finish) begin
        ns_r  <= 1'b0;
        neg_r <= 1'b0;
        ind_r <= 1'b0;
        ovf_r <= 1'b0;
        cur_r <= '0;
        grp_r <= '0;
        cnt_r <= '0;
      end else begin
        ns_r  <= ns_nxt;
        neg_r <= neg_nxt;
        ind_r <= ind_nxt;
        ovf_r <= ovf_nxt;
        cur_r <= cur_nxt;
        grp_r <= grp_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

>>> rtl/cisu_fifo.sv
// ----------------------------------------------------------------------------
// cisu_fifo
// Short register queue between the parser and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module cisu_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             not_empty
);
  import cisu_pkg::*;

  localparam int unsigned PtrW = $clog2(QDEPTH);
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] mem [QDEPTH];
  logic [PtrW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]  cnt_r;
  logic             do_wr, do_rd;

  assign full      = (cnt_r == CntW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/cisu_back.sv
// ----------------------------------------------------------------------------
// cisu_back
// Three-stage arithmetic pipeline: weighted products, pair sums, then the
// final signed sum with error selection into the output register.
// ----------------------------------------------------------------------------
module cisu_back #(
  parameter int unsigned MAX_GROUPS = 4
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  cisu_pkg::mode_t                              mode,
  input  logic                                         q_valid,
  input  cisu_pkg::str_info_t                          q_info,
  input  logic [MAX_GROUPS-1:0][cisu_pkg::GROUP_W-1:0] q_groups,
  output logic                                         q_pop,
  cisu_out_if.source                                   out_ch
);
  import cisu_pkg::*;

  localparam gcnt_t MaxG = gcnt_t'(MAX_GROUPS);

  prod_t prod [4];
  gcnt_t mg, used;
  err_t  err_s0;

  logic  v1_r, v2_r, v3_r;
  logic  adv1, adv2, adv3;
  prod_t p_r [4];
  logic  neg1_r, kill1_r, neg2_r, kill2_r;
  err_t  err1_r, err2_r, err3_r;
  prod_t s01_r, s23_r;
  prod_t tot_r;

  // Lane i carries the i-th most recent group; a weight of zero drops it.
  for (genvar i = 0; i < 4; i++) begin : g_lane
    if (i >= MAX_GROUPS) begin : g_none
      assign prod[i] = '0;
    end else if (i == 0) begin : g_w0
      assign prod[i] = {1'b0, q_groups[i]};
    end else if (i == 1) begin : g_w1
      prod_t g;
      assign g = {1'b0, q_groups[i]};
      always_comb begin
        case (mode)
          MODE_DAY_HOUR:   prod[i] = g * W_24;
          MODE_YEAR_MONTH: prod[i] = g * W_12;
          default:         prod[i] = g * W_60;
        endcase
      end
    end else if (i == 2) begin : g_w2
      prod_t g;
      assign g = {1'b0, q_groups[i]};
      always_comb begin
        case (mode)
          MODE_HOUR_SEC, MODE_DAY_SEC: prod[i] = g * W_3600;
          MODE_DAY_MIN:                prod[i] = g * W_1440;
          MODE_HOUR_MIN, MODE_MIN_SEC,
          MODE_DAY_HOUR, MODE_YEAR_MONTH: prod[i] = '0;
          default:                     prod[i] = g * W_3600;
        endcase
      end
    end else begin : g_w3
      prod_t g;
      assign g = {1'b0, q_groups[i]};
      assign prod[i] = (mode == MODE_DAY_SEC) ? g * W_86400 : '0;
    end
  end

  always_comb begin
    mg   = mode_groups(mode);
    used = (mg > MaxG) ? MaxG : mg;
    if (q_info.cnt > used) begin
      err_s0 = ERR_GROUPS;
    end else if (q_info.ovf) begin
      err_s0 = ERR_RANGE;
    end else begin
      err_s0 = ERR_OK;
    end
    if (q_info.zero) begin
      err_s0 = ERR_OK;
    end
  end

  assign adv3  = !v3_r || out_ch.ready;
  assign adv2  = !v2_r || adv3;
  assign adv1  = !v1_r || adv2;
  assign q_pop = adv1 && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= q_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < 4; i++) begin
        p_r[i] <= prod[i];
      end
      neg1_r  <= q_info.neg;
      kill1_r <= q_info.zero || (err_s0 != ERR_OK);
      err1_r  <= err_s0;
    end
    if (adv2) begin
      s01_r   <= p_r[0] + p_r[1];
      s23_r   <= p_r[2] + p_r[3];
      neg2_r  <= neg1_r;
      kill2_r <= kill1_r;
      err2_r  <= err1_r;
    end
    if (adv3) begin
      // Negated sum as ~a + ~b + 2, which equals -(a + b) modulo 2^64.
      if (kill2_r) begin
        tot_r <= '0;
      end else if (neg2_r) begin
        tot_r <= ~s01_r + ~s23_r + 64'd2;
      end else begin
        tot_r <= s01_r + s23_r;
      end
      err3_r <= err2_r;
    end
  end

  assign out_ch.valid       = v3_r;
  assign out_ch.total_value = total_t'(tot_r);
  assign out_ch.error_code  = err3_r;

endmodule

>>> rtl/combined_interval_string_to_units_top.sv
// ----------------------------------------------------------------------------
// combined_interval_string_to_units_top
// Converts an interval string such as "-1:02:03", one byte per beat, into a
// signed count of the selected mode's smallest unit.
// ----------------------------------------------------------------------------
//  channel  direction  beat contents
//  in_ch    sink       char_code, last_char, empty_row
//  out_ch   source     total_value, error_code (one beat per string)
//  cfg_*    write      unit_mode, written with cfg_we
//
// One byte is accepted every cycle while the parser-to-pipeline queue has
// room. A result passes from the beat that ends its string through the queue
// and the product, pair-sum and final-sum stages. A stalled output holds
// the pipeline, then fills the two-entry queue, and only then drops in_ready.
// Reset is synchronous and active low and needs no clearing pass.
// ----------------------------------------------------------------------------
module combined_interval_string_to_units_top #(
  parameter int unsigned MAX_GROUPS = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  cisu_pkg::mode_t cfg_wdata,
  cisu_in_if.sink         in_ch,
  cisu_out_if.source      out_ch
);
  import cisu_pkg::*;

  localparam int unsigned GrpW = MAX_GROUPS * GROUP_W;
  localparam int unsigned RecW = GrpW + $bits(str_info_t);

  mode_t                              mode_r;
  logic                               push, q_full, q_valid, q_pop;
  str_info_t                          push_info, q_info;
  logic [MAX_GROUPS-1:0][GROUP_W-1:0] push_groups, q_groups;
  logic [RecW-1:0]                    q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HOUR_SEC;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  cisu_front #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (in_ch.valid),
    .char_code   (in_ch.char_code),
    .last_char   (in_ch.last_char),
    .empty_row   (in_ch.empty_row),
    .q_full      (q_full),
    .byte_ready  (in_ch.ready),
    .push        (push),
    .push_info   (push_info),
    .push_groups (push_groups)
  );

  assign q_wdata  = {push_info, push_groups};
  assign q_info   = str_info_t'(q_rdata[RecW-1:GrpW]);
  assign q_groups = q_rdata[GrpW-1:0];

  cisu_fifo #(
    .WIDTH (RecW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (push),
    .wr_data   (q_wdata),
    .rd_en     (q_pop),
    .rd_data   (q_rdata),
    .full      (q_full),
    .not_empty (q_valid)
  );

  cisu_back #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mode     (mode_r),
    .q_valid  (q_valid),
    .q_info   (q_info),
    .q_groups (q_groups),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the interval string converter. Strings are fed one
// byte per beat under random source gaps and sink stalls. A local model of
// the parser and the unit arithmetic predicts each interval, and every result
// beat is checked field by field against the oldest prediction. The run
// covers every unit mode, including the spare code, digit runs around the
// Int64 limit, surplus groups, empty rows and arbitrary bytes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cisu_pkg::*;

  localparam int unsigned MAX_GROUPS    = 4;
  localparam int unsigned PHASE_BEATS   = 100;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned DRAIN_LIMIT   = 5000;

  localparam mode_t MODE_SPARE = 3'd7;
  localparam char_t CH_COLON   = 8'h3A;
  localparam char_t CH_PLUS    = 8'h2B;

  typedef struct {
    total_t total;
    err_t   err;
  } interval_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  mode_t cfg_wdata;

  cisu_in_if  in_ch ();
  cisu_out_if out_ch ();

  combined_interval_string_to_units_top #(
    .MAX_GROUPS(MAX_GROUPS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #1 clk = ~clk;

  // Local copy of the converter state.
  mode_t       unit_mode_q;
  logic        nonspace_seen;
  logic        minus_lead;
  logic        in_run;
  logic        run_ovf;
  group_t      run_value;
  group_t      groups [MAX_GROUPS];
  int unsigned run_count;

  interval_result_t pending_intervals [$];
  char_t            str_buf [$];

  bit          src_gaps_on   = 1'b0;
  bit          sink_stall_on = 1'b0;
  int unsigned row_drop_pct  = 0;
  int unsigned ready_hold    = 0;
  int unsigned failures      = 0;
  int unsigned beats_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned error_results = 0;
  int unsigned modes_written = 0;

  // Mostly back to back, now and then a short pause, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void shuffle_idling();
    src_gaps_on   = ($urandom_range(0, 3) != 0);
    sink_stall_on = ($urandom_range(0, 3) != 0);
  endfunction

  // Weight of each group, most recent group first. A zero weight marks a
  // group that the mode does not use; the spare code falls back to hour-sec.
  function automatic prod_t unit_weight(mode_t m, int unsigned idx);
    prod_t w [4];
    case (m)
      MODE_HOUR_MIN:   w = '{64'd1, W_60, 64'd0, 64'd0};
      MODE_MIN_SEC:    w = '{64'd1, W_60, 64'd0, 64'd0};
      MODE_DAY_SEC:    w = '{64'd1, W_60, W_3600, W_86400};
      MODE_DAY_MIN:    w = '{64'd1, W_60, W_1440, 64'd0};
      MODE_DAY_HOUR:   w = '{64'd1, W_24, 64'd0, 64'd0};
      MODE_YEAR_MONTH: w = '{64'd1, W_12, 64'd0, 64'd0};
      default:         w = '{64'd1, W_60, W_3600, 64'd0};
    endcase
    return w[idx];
  endfunction

  function automatic int unsigned groups_in_mode(mode_t m);
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < 4; i++) begin
      if (unit_weight(m, i) != 0) n++;
    end
    return (n > MAX_GROUPS) ? MAX_GROUPS : n;
  endfunction

  function automatic void clear_string();
    nonspace_seen = 1'b0;
    minus_lead    = 1'b0;
    in_run        = 1'b0;
    run_ovf       = 1'b0;
    run_value     = '0;
    run_count     = 0;
    foreach (groups[i]) groups[i] = '0;
  endfunction

  function automatic void close_run();
    for (int i = MAX_GROUPS - 1; i > 0; i--) groups[i] = groups[i - 1];
    groups[0] = run_value;
    if (run_count < MAX_GROUPS + 1) run_count++;
    run_value = '0;
    in_run    = 1'b0;
  endfunction

  function automatic void parse_char(char_t c);
    logic [63:0] digit;
    if (!nonspace_seen && c != CH_SPACE) begin
      nonspace_seen = 1'b1;
      minus_lead    = (c == CH_MINUS);
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit  = 64'(c - CH_ZERO);
      in_run = 1'b1;
      // A run that would pass the Int64 maximum pins there and flags it.
      if ({1'b0, run_value} > (64'(GROUP_MAX) - digit) / 64'd10) begin
        run_value = GROUP_MAX;
        run_ovf   = 1'b1;
      end else begin
        run_value = group_t'({1'b0, run_value} * 64'd10 + digit);
      end
    end else if (in_run) begin
      close_run();
    end
  endfunction

  function automatic void predict_interval(char_t c, logic last, logic empty);
    interval_result_t res;
    logic [63:0]      sum;
    int unsigned      used;
    if (empty) begin
      clear_string();
      res.total = '0;
      res.err   = ERR_OK;
      pending_intervals.push_back(res);
      return;
    end
    parse_char(c);
    if (!last) return;
    if (in_run) close_run();
    used = groups_in_mode(unit_mode_q);
    sum  = '0;
    if (run_count > used) begin
      res.err = ERR_GROUPS;
    end else if (run_ovf) begin
      res.err = ERR_RANGE;
    end else begin
      res.err = ERR_OK;
      for (int unsigned i = 0; i < used; i++) begin
        sum += {1'b0, groups[i]} * unit_weight(unit_mode_q, i);
      end
      if (minus_lead) sum = 64'd0 - sum;
    end
    res.total = (res.err == ERR_OK) ? total_t'(sum) : '0;
    if (res.err != ERR_OK) error_results++;
    pending_intervals.push_back(res);
    clear_string();
  endfunction

  task automatic send_beat(input char_t c, input logic last, input logic empty);
    int unsigned gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last_char <= last;
    in_ch.empty_row <= empty;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_interval(c, last, empty);
    beats_sent++;
  endtask

  // Sends the buffered string, its final byte flagged as last. Now and then
  // an empty row cuts in and throws away what has been read so far.
  task automatic send_text();
    foreach (str_buf[i]) begin
      if ($urandom_range(0, 99) < row_drop_pct) begin
        send_beat(char_t'($urandom), 1'($urandom), 1'b1);
      end
      send_beat(str_buf[i], i == str_buf.size() - 1, 1'b0);
    end
  endtask

  task automatic send_literal(input string s);
    str_buf.delete();
    for (int i = 0; i < s.len(); i++) str_buf.push_back(char_t'(s[i]));
    send_text();
  endtask

  function automatic char_t pick_separator();
    char_t sep;
    if ($urandom_range(0, 9) < 7) return CH_COLON;
    do sep = char_t'($urandom_range(0, 255)); while (sep >= CH_ZERO && sep <= CH_NINE);
    return sep;
  endfunction

  // Digit runs just below, at and beyond the Int64 limit, or padded with leading zeros.
  function automatic void push_long_run();
    string max_prefix;
    max_prefix = "922337203685477580";
    case ($urandom_range(0, 3))
      0, 1: begin
        for (int i = 0; i < max_prefix.len(); i++) str_buf.push_back(char_t'(max_prefix[i]));
        str_buf.push_back(CH_ZERO + char_t'($urandom_range(6, 9)));
      end
      2: begin
        str_buf.push_back(CH_NINE);
        repeat ($urandom_range(17, 20)) str_buf.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
      end
      default: begin
        repeat ($urandom_range(15, 25)) str_buf.push_back(CH_ZERO);
        str_buf.push_back(CH_ZERO + char_t'($urandom_range(1, 9)));
      end
    endcase
  endfunction

  // Mostly well formed intervals with random content; a share is pure noise.
  function automatic void build_interval(int unsigned long_pct);
    int unsigned n_groups, span, r;
    str_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) str_buf.push_back(char_t'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) str_buf.push_back(CH_SPACE);
    r = $urandom_range(0, 99);
    if (r < 35) str_buf.push_back(CH_MINUS);
    else if (r < 45) str_buf.push_back(CH_PLUS);
    else if (r < 50) str_buf.push_back(pick_separator());
    span = groups_in_mode(unit_mode_q);
    r = $urandom_range(0, 99);
    if (r < 8) n_groups = 0;
    else if (r < 82) n_groups = $urandom_range(1, span);
    else n_groups = span + $urandom_range(1, 2);
    for (int unsigned g = 0; g < n_groups; g++) begin
      if (g != 0) begin
        str_buf.push_back(pick_separator());
        if ($urandom_range(0, 9) == 0) str_buf.push_back(CH_SPACE);
      end
      if ($urandom_range(0, 99) < long_pct) push_long_run();
      else repeat ($urandom_range(1, 3)) str_buf.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 4) == 0) str_buf.push_back(pick_separator());
    if (str_buf.size() == 0) str_buf.push_back(CH_SPACE);
  endfunction

  // Lets every expected result drain, then waits out the pipeline.
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (pending_intervals.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_intervals.size() != 0) begin
      $error("%0d expected results never arrived", pending_intervals.size());
      failures++;
      pending_intervals.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_unit_mode(input mode_t m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we      <= 1'b0;
    unit_mode_q  = m;
    modes_written++;
  endtask

  // Reset mode hour-sec: a signed and an unsigned interval.
  task automatic test_basic_conversion();
    row_drop_pct = 0;
    send_literal("-1:02:03");
    send_literal(" 4:5");
  endtask

  task automatic test_special_cases();
    row_drop_pct = 0;
    // An empty row flagged as last as well still gives a single zero.
    send_beat(8'h00, 1'b1, 1'b1);
    // A partly read string is dropped by an empty row.
    send_beat(CH_ZERO + 8'd7, 1'b0, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_literal("  ");
    send_literal("1:2:3:4");
    send_beat(8'hFF, 1'b1, 1'b0);
  endtask

  task automatic test_group_range();
    int unsigned target;
    set_unit_mode(MODE_HOUR_SEC);
    row_drop_pct = 0;
    shuffle_idling();
    target = beats_sent + PHASE_BEATS;
    while (beats_sent < target) begin
      build_interval(60);
      send_text();
    end
  endtask

  task automatic test_unit_modes();
    mode_t       sweep [8];
    int unsigned target;
    sweep = '{MODE_YEAR_MONTH, MODE_HOUR_MIN, MODE_DAY_SEC, MODE_SPARE,
              MODE_MIN_SEC, MODE_DAY_MIN, MODE_DAY_HOUR, MODE_HOUR_SEC};
    row_drop_pct = 2;
    foreach (sweep[k]) begin
      set_unit_mode(sweep[k]);
      shuffle_idling();
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        if ($urandom_range(0, 29) == 0) shuffle_idling();
        if ($urandom_range(0, 32) == 0) begin
          send_beat(char_t'($urandom), 1'($urandom), 1'b1);
        end else begin
          build_interval(6);
          send_text();
        end
      end
    end
  endtask

  // Result sink: ready drops for random stretches while stalls are enabled.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (sink_stall_on && out_ch.ready) begin
      out_ch.ready <= 1'b0;
      ready_hold   <= pick_gap();
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin : check_results
    interval_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_intervals.size() == 0) begin
        $error("unexpected result beat: total_value %0d, error_code %0d",
               out_ch.total_value, out_ch.error_code);
        failures++;
      end else begin
        want = pending_intervals.pop_front();
        results_seen++;
        if (out_ch.total_value !== want.total) begin
          $error("total_value: expected %0d, got %0d", want.total, out_ch.total_value);
          failures++;
        end
        if (out_ch.error_code !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, out_ch.error_code);
          failures++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("combined_interval_string_to_units_top verification failed");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = MODE_HOUR_SEC;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last_char = 1'b0;
    in_ch.empty_row = 1'b0;
    out_ch.ready    = 1'b0;
    unit_mode_q     = MODE_HOUR_SEC;
    clear_string();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_conversion();
    test_special_cases();
    test_group_range();
    test_unit_modes();
    wait_idle();

    $display("Sent %0d byte beats over %0d unit mode settings, spare code included.",
             beats_sent, modes_written);
    $display("Checked %0d intervals, %0d of them carrying an error code.",
             results_seen, error_results);
    if (failures == 0) begin
      $display("combined_interval_string_to_units_top verification clean");
    end else begin
      $display("combined_interval_string_to_units_top verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/cisu_pkg.sv
rtl/cisu_if.sv
rtl/cisu_front.sv
rtl/cisu_fifo.sv
rtl/cisu_back.sv
rtl/combined_interval_string_to_units_top.sv
test/tb_top.sv
